@@ rtl/core/square_wave_melody_sequencer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Square wave melody sequencer assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAVE_MELODY_SEQUENCER_TOP_ASSERT_SVH
`define SQUARE_WAVE_MELODY_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define SWMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SWMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/swms_pkg.sv @@
// ----------------------------------------------------------------------------
// Square wave melody sequencer package
// Transfer types, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package swms_pkg;

    localparam int DIV_W      = 20;
    localparam int DIV_CNT_W  = 5;
    localparam int TICK_W     = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME      = 1'd1;

    localparam logic [19:0] SAMPLE_RATE_RST = 20'd44100;
    localparam logic [11:0] VOLUME_RST      = 12'd1024;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  entry_index;
        logic [15:0] note_freq;
        logic [15:0] note_duration;
        logic [5:0]  song_start;
        logic [6:0]  song_length;
    } swms_in_t;

    typedef struct packed {
        logic [11:0] sample;
        logic        playing;
    } swms_out_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
    } swms_entry_t;

endpackage

`default_nettype wire

@@ rtl/core/swms_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/square_wave_melody_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Square wave melody sequencer
// Note table in RAM; a shared restoring divider gives period and phase.
// ----------------------------------------------------------------------------
// Playing tick: 20-step divider pass for the period, then for the phase if nonzero.
// Idle tick goes straight to emit; note write is taken in idle; start wraps the index.
// One item at a time; the next item is taken while a result waits on m_.
// Reset: synchronous active low; idle, counters zero, registers at defaults,
// note table undefined until written.
`default_nettype none

module square_wave_melody_sequencer_top
    import swms_pkg::*;
#(
    parameter int NOTE_DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire swms_in_t              s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output swms_out_t                  m_payload,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int AW      = $clog2(NOTE_DEPTH);
    localparam int LEN_MAX = (NOTE_DEPTH < 127) ? NOTE_DEPTH : 127;
    localparam int END_W   = $clog2(63 + LEN_MAX + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WRAP = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic                active_reg, active_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [END_W-1:0]    note_reg, note_next;
    logic [END_W-1:0]    end_reg, end_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [19:0]         sample_rate_reg, sample_rate_next;
    logic [11:0]         volume_reg, volume_next;

    logic [5:0]          wrap_reg, wrap_next;
    logic [15:0]         dur_reg, dur_next;
    logic [DIV_W-1:0]    period_reg, period_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DIV_W-1:0]    den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                phase_reg, phase_next;
    logic                hi_reg, hi_next;
    swms_out_t           out_reg, out_next;

    swms_entry_t         ram_wdata;
    swms_entry_t         ram_rdata;
    logic                ram_we;

    logic                in_xfer;
    logic [DIV_W:0]      rem_sh;
    logic [DIV_W:0]      rem_diff;
    logic                fits;
    logic [DIV_W-1:0]    rem_step;
    logic [DIV_W-1:0]    quo_step;
    logic [TICK_W-1:0]   tick_inc;
    logic [END_W-1:0]    len_sat;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    assign ram_wdata.freq = s_payload.note_freq;
    assign ram_wdata.dur  = s_payload.note_duration;
    assign ram_we = in_xfer && (s_payload.op == OP_WRITE)
                    && (32'(s_payload.entry_index) < NOTE_DEPTH);

    swms_ram #(
        .WIDTH ($bits(swms_entry_t)),
        .DEPTH (NOTE_DEPTH)
    ) u_note_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(s_payload.entry_index)),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // restoring divider step
    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign fits     = (rem_sh >= {1'b0, den_reg});
    assign rem_step = fits ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    assign quo_step = {quo_reg[DIV_W-2:0], fits};

    assign tick_inc = tick_reg + TICK_W'(1);
    assign len_sat  = (32'(s_payload.song_length) > NOTE_DEPTH) ? END_W'(NOTE_DEPTH)
                                                                : END_W'(s_payload.song_length);

    always_comb begin
        state_next       = state_reg;
        active_next      = active_reg;
        tick_next        = tick_reg;
        note_next        = note_reg;
        end_next         = end_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg;
        sample_rate_next = sample_rate_reg;
        volume_next      = volume_reg;
        wrap_next        = wrap_reg;
        dur_next         = dur_reg;
        period_next      = period_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        den_next         = den_reg;
        cnt_next         = cnt_reg;
        phase_next       = phase_reg;
        hi_next          = hi_reg;
        out_next         = out_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLE_RATE: sample_rate_next = cfg_wr_data[19:0];
                CFG_VOLUME:      volume_next      = cfg_wr_data[11:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_payload.op)
                        OP_TICK: begin
                            hi_next    = 1'b0;
                            state_next = active_reg ? S_LOAD : S_EMIT;
                        end
                        OP_START: begin
                            tick_next   = '0;
                            note_next   = END_W'(s_payload.song_start);
                            end_next    = END_W'(s_payload.song_start) + len_sat;
                            active_next = (s_payload.song_length != 7'd0);
                            wrap_next   = s_payload.song_start;
                            state_next  = S_WRAP;
                        end
                        default: ;
                    endcase
                end
            end
            S_WRAP: begin
                if (32'(wrap_reg) >= NOTE_DEPTH) begin
                    wrap_next = wrap_reg - 6'(NOTE_DEPTH);
                end else begin
                    slot_next  = AW'(wrap_reg);
                    state_next = S_IDLE;
                end
            end
            S_LOAD: begin
                dur_next   = ram_rdata.dur;
                rem_next   = '0;
                quo_next   = sample_rate_reg;
                den_next   = DIV_W'(ram_rdata.freq);
                cnt_next   = DIV_CNT_W'(DIV_W);
                phase_next = 1'b0;
                state_next = (ram_rdata.freq == 16'd0) ? S_EMIT : S_DIV;
            end
            S_DIV: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    if (!phase_reg) begin
                        period_next = quo_step;
                        if (quo_step == '0) begin
                            state_next = S_EMIT;
                        end else begin
                            rem_next   = '0;
                            quo_next   = DIV_W'(tick_inc);
                            den_next   = quo_step;
                            cnt_next   = DIV_CNT_W'(DIV_W);
                            phase_next = 1'b1;
                        end
                    end else begin
                        hi_next    = (rem_step > (period_reg >> 1));
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_next.sample  = hi_reg ? volume_reg : 12'd0;
                    out_next.playing = 1'b0;
                    if (active_reg) begin
                        if ({1'b0, tick_inc} > {2'b0, dur_reg}) begin
                            tick_next   = '0;
                            note_next   = note_reg + END_W'(1);
                            slot_next   = (slot_reg == AW'(NOTE_DEPTH - 1)) ? '0
                                                                            : slot_reg + AW'(1);
                            active_next = ((note_reg + END_W'(1)) < end_reg);
                            out_next.playing = ((note_reg + END_W'(1)) < end_reg);
                        end else begin
                            tick_next   = tick_inc;
                            active_next = (note_reg < end_reg);
                            out_next.playing = (note_reg < end_reg);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            active_reg      <= 1'b0;
            tick_reg        <= '0;
            note_reg        <= '0;
            end_reg         <= '0;
            slot_reg        <= '0;
            out_valid_reg   <= 1'b0;
            sample_rate_reg <= SAMPLE_RATE_RST;
            volume_reg      <= VOLUME_RST;
        end else begin
            state_reg       <= state_next;
            active_reg      <= active_next;
            tick_reg        <= tick_next;
            note_reg        <= note_next;
            end_reg         <= end_next;
            slot_reg        <= slot_next;
            out_valid_reg   <= out_valid_next;
            sample_rate_reg <= sample_rate_next;
            volume_reg      <= volume_next;
        end
    end

    always_ff @(posedge aclk) begin
        wrap_reg   <= wrap_next;
        dur_reg    <= dur_next;
        period_reg <= period_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        cnt_reg    <= cnt_next;
        phase_reg  <= phase_next;
        hi_reg     <= hi_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/swms_checker.sv @@
// ----------------------------------------------------------------------------
// Square wave melody sequencer port checker
// Watches the top level ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_wave_melody_sequencer_top_assert.svh"

module swms_checker
    import swms_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire swms_in_t              s_payload,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire swms_out_t             m_payload
);

    logic tick_or_start;
    logic note_write;

    assign tick_or_start = s_valid && s_ready
                           && ((s_payload.op == OP_TICK) || (s_payload.op == OP_START));
    assign note_write    = s_valid && s_ready && (s_payload.op == OP_WRITE);

    `SWMS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))
    `SWMS_ASSERT_NEXT(a_busy_after_item, tick_or_start, !s_ready)
    `SWMS_ASSERT_NEXT(a_write_single_cycle, note_write, s_ready)
    `SWMS_ASSERT_SAME(a_out_known, m_valid, !$isunknown(m_payload))

endmodule

bind square_wave_melody_sequencer_top swms_checker u_swms_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Square wave melody sequencer testbench
// Directed and random transfers on the valid/ready item channel, with a local
// model of the note table, tick counter and song position predicting each
// sample. Both channels idle at random; register settings change between
// phases once all samples have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import swms_pkg::*;

    localparam int          NOTE_DEPTH  = 64;
    localparam logic [1:0]  OP_UNKNOWN  = 2'd3;
    localparam int          SETTLE      = 100;
    localparam int          LONG_HOLD   = 400;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    swms_in_t              s_payload;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    swms_out_t             m_payload;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    square_wave_melody_sequencer_top #(
        .NOTE_DEPTH(NOTE_DEPTH)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // sequencer model state
    logic [15:0] freq_table [NOTE_DEPTH];
    logic [15:0] dur_table  [NOTE_DEPTH];
    logic [16:0] tick_cnt;
    logic [6:0]  note_pos;
    logic [6:0]  note_end;
    logic        song_active;
    logic [19:0] rate;
    logic [11:0] level;

    swms_out_t   tone_queue [$];
    int          bad_results = 0;
    int unsigned cycle_count = 0;

    int          burst_left = 0;
    bit          no_gaps = 1'b0;

    int          hold_requests = 0;
    int          holds_seen = 0;
    int          hold_left = 0;
    int          ready_mode = 0;
    int          mode_left = 0;

    task automatic advance_sequencer(input swms_in_t it);
        int unsigned len;
        int unsigned slot;
        int unsigned freq;
        int unsigned period;
        int unsigned tc;
        swms_out_t   res;
        case (it.op)
            OP_WRITE: begin
                freq_table[it.entry_index] = it.note_freq;
                dur_table[it.entry_index]  = it.note_duration;
            end
            OP_START: begin
                len = it.song_length;
                if (len > NOTE_DEPTH) len = NOTE_DEPTH;
                tick_cnt    = '0;
                note_pos    = {1'b0, it.song_start};
                note_end    = 7'(it.song_start + len);
                song_active = (len != 0);
            end
            OP_TICK: begin
                res = '0;
                if (song_active) begin
                    slot   = note_pos % NOTE_DEPTH;
                    freq   = freq_table[slot];
                    period = (freq != 0) ? (rate / freq) : 0;
                    tick_cnt = tick_cnt + 17'd1;
                    tc = tick_cnt;
                    if (period != 0 && (tc % period) > (period >> 1)) res.sample = level;
                    if (tc > dur_table[slot]) begin
                        note_pos = note_pos + 7'd1;
                        tick_cnt = '0;
                    end
                    if (note_pos >= note_end) song_active = 1'b0;
                    res.playing = song_active;
                end
                tone_queue.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic swms_in_t random_item(input logic [1:0] op);
        logic [63:0] raw;
        swms_in_t    it;
        raw = {$urandom, $urandom};
        it = raw[$bits(swms_in_t)-1:0];
        it.op = op;
        return it;
    endfunction

    function automatic swms_in_t make_write(input logic [5:0] idx, input logic [15:0] freq,
                                            input logic [15:0] dur);
        swms_in_t it;
        it = random_item(OP_WRITE);
        it.entry_index   = idx;
        it.note_freq     = freq;
        it.note_duration = dur;
        return it;
    endfunction

    function automatic swms_in_t make_start(input logic [5:0] start, input logic [6:0] len);
        swms_in_t it;
        it = random_item(OP_START);
        it.song_start  = start;
        it.song_length = len;
        return it;
    endfunction

    function automatic logic [15:0] pick_freq();
        int unsigned r;
        int unsigned f;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 4) return 16'($urandom);
        f = rate / $urandom_range(2, 40);
        if (f == 0) f = 1;
        if (f > 65535) f = $urandom_range(1, 65535);
        return 16'(f);
    endfunction

    function automatic logic [15:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8) return 16'($urandom_range(0, 6));
        if (r == 8) return 16'($urandom_range(7, 200));
        return 16'($urandom);
    endfunction

    function automatic logic [6:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 7'($urandom_range(1, 6));
        if (r == 6) return '0;
        if (r == 7) return 7'($urandom_range(7, 64));
        if (r == 8) return 7'($urandom_range(65, 127));
        return 7'($urandom_range(1, 3));
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_item(input swms_in_t it);
        int gap;
        if (!no_gaps && burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                5, 6, 7:       gap = $urandom_range(4, 20);
                default:       gap = $urandom_range(21, 70);
            endcase
            burst_left = $urandom_range(1, 24);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left > 0) burst_left--;
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_sequencer(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tone_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [19:0] sr, input logic [11:0] vol);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SAMPLE_RATE;
        cfg_wr_data <= CFG_DATA_W'(sr);
        @(posedge aclk);
        cfg_index   <= CFG_VOLUME;
        cfg_wr_data <= CFG_DATA_W'(vol);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        rate  = sr;
        level = vol;
    endtask

    task automatic test_idle_and_unknown_op();
        send_item(random_item(OP_TICK));
        send_item(random_item(OP_UNKNOWN));
        send_item(random_item(OP_TICK));
    endtask

    task automatic test_table_write();
        send_item(make_write(6'd0,  16'd11025, 16'd3));
        send_item(make_write(6'd1,  16'd0,     16'd1));
        send_item(make_write(6'd63, 16'hffff,  16'd0));
        send_item(make_write(6'd2,  16'd1,     16'hffff));
    endtask

    task automatic test_song_playback();
        send_item(make_start(6'd0, 7'd2));
        repeat (7) send_item(random_item(OP_TICK));
    endtask

    // last entry wraps round to entry zero
    task automatic test_index_wrap();
        send_item(make_start(6'd63, 7'd2));
        repeat (3) send_item(random_item(OP_TICK));
    endtask

    task automatic test_song_length_limits();
        send_item(make_start(6'd5, 7'd0));
        send_item(random_item(OP_TICK));
        send_item(make_start(6'd2, 7'd127));
        send_item(random_item(OP_TICK));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        no_gaps = 1'b1;
        hold_requests <= hold_requests + 1;
        send_item(make_start(6'($urandom_range(0, 63)), 7'd8));
        repeat (40) send_item(random_item(OP_TICK));
        no_gaps = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phase(input int n, input logic [19:0] sr,
                                     input logic [11:0] vol, input bit load_table);
        int       count;
        int       r;
        swms_in_t it;
        set_config(sr, vol);
        count = 0;
        if (load_table) begin
            for (int i = 0; i < NOTE_DEPTH; i++) begin
                send_item(make_write(6'(i), pick_freq(), pick_duration()));
                count++;
            end
        end
        while (count < n) begin
            r = $urandom_range(0, 99);
            if (r < 7) it = make_write(6'($urandom_range(0, 63)), pick_freq(), pick_duration());
            else if (r < 11) it = make_start(6'($urandom_range(0, 63)), pick_length());
            else if (r < 13) it = random_item(OP_UNKNOWN);
            else it = random_item(OP_TICK);
            send_item(it);
            if (it.op != OP_UNKNOWN) count++;
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_payload   <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_wr_data <= '0;
        rate        = SAMPLE_RATE_RST;
        level       = VOLUME_RST;
        tick_cnt    = '0;
        note_pos    = '0;
        note_end    = '0;
        song_active = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_and_unknown_op();
        test_table_write();
        test_song_playback();
        test_index_wrap();
        test_song_length_limits();
        test_random_phase(300, 20'd44100, 12'd4095, 1'b1);
        test_output_backpressure();
        test_random_phase(200, 20'd1, 12'd4095, 1'b0);
        test_random_phase(250, 20'hfffff, 12'd2730, 1'b0);
        test_random_phase(150, 20'($urandom_range(1, 1048575)), 12'd0, 1'b0);
        test_random_phase(250, 20'($urandom_range(1, 1048575)), 12'($urandom), 1'b0);
        test_random_phase(150, 20'($urandom_range(8000, 96000)), 12'($urandom), 1'b0);

        wait_idle();
        if (bad_results == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver: random ready pattern, with one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != holds_seen) begin
            holds_seen <= hold_requests;
            hold_left  <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        swms_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tone_queue.size() == 0) begin
                if (bad_results < 10) begin
                    $display("unexpected sample transfer: sample %0d playing %0d",
                             m_payload.sample, m_payload.playing);
                end
                bad_results++;
            end else begin
                want = tone_queue.pop_front();
                if (want.sample !== m_payload.sample || want.playing !== m_payload.playing) begin
                    if (bad_results < 10) begin
                        $display("sample mismatch: expected sample %0d playing %0d, got sample %0d playing %0d",
                                 want.sample, want.playing, m_payload.sample, m_payload.playing);
                    end
                    bad_results++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/swms_pkg.sv
rtl/core/swms_ram.sv
rtl/core/square_wave_melody_sequencer_top.sv
rtl/core/swms_checker.sv
tb/tb.sv
